// ----- hdl/fdbd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdbd_pkg
// shared types, constants and the toggle mask table for the descrambler
// ----------------------------------------------------------------------------
package fdbd_pkg;

    localparam int unsigned FibW   = 32;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned QuoW   = 29;   // floor((2^32-1)/10) fits in 29 bits
    localparam int unsigned DigitW = 3;

    // reciprocal of 10 scaled by 2^35
    localparam logic [FibW-1:0] RecipTen   = 32'hCCCC_CCCD;
    localparam int unsigned     RecipShift = 35;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_FILL,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } fdbd_state_t;

    typedef enum logic {
        DIG_SHIFT  = 1'b0,
        DIG_TOGGLE = 1'b1
    } fdbd_digit_t;

    // controller to datapath
    typedef struct packed {
        logic        load;      // capture input word (seeds restart the pair)
        logic        fib_step;  // one seed advance of the pair
        logic        fill;      // reload digit source from the pair
        logic        mul;       // reciprocal multiply of the source magnitude
        logic        div;       // finish the digit draw
        fdbd_digit_t digit;     // which digit the draw produces
        logic        out_load;  // load the result register
    } fdbd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic src_zero;
        logic cnt_zero;
        logic out_busy;
    } fdbd_sts_t;

    function automatic logic [ByteW-1:0] toggle_mask(input logic [DigitW-1:0] idx);
        logic [ByteW-1:0] m;
        unique case (idx)
            3'd0:    m = 8'h00;
            3'd1:    m = 8'h01;
            3'd2:    m = 8'h02;
            3'd3:    m = 8'h04;
            3'd4:    m = 8'h08;
            3'd5:    m = 8'h10;
            3'd6:    m = 8'h20;
            default: m = 8'h80;
        endcase
        return m;
    endfunction

endpackage

// ----- hdl/fibonacci_digit_byte_descrambler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fibonacci_digit_byte_descrambler
// data words: taken only when idle, each by two digit draws of refill,
//   reciprocal multiply and remainder through one divide unit
// seed word n: the pair restarts, then steps n times, one fibonacci step per cycle
// reset: aresetn synchronous active low, pair (1,0), digit source 0, no result
// ----------------------------------------------------------------------------
module fibonacci_digit_byte_descrambler
    import fdbd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] first_byte (seed word)
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [7:0] plain_byte
);

    fdbd_cmd_t cmd;
    fdbd_sts_t sts;

    // sequencer: accepts words only when idle, the result register lets the
    // next word enter while a finished word still waits downstream
    fdbd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_first  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // fibonacci state, divide-by-ten draw and byte decode
    fdbd_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_data   (s_tdata),
        .s_first  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_data   (m_tdata)
    );

endmodule

// ----- hdl/fdbd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdbd_ctrl
// sequencer for seed advance, two digit draws and result hand-off
// ----------------------------------------------------------------------------
module fdbd_ctrl
    import fdbd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      s_first,
    output logic      s_tready,
    input  fdbd_sts_t sts,
    output fdbd_cmd_t cmd
);

    fdbd_state_t state_reg, state_next;
    fdbd_digit_t digit_reg, digit_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            digit_reg <= DIG_SHIFT;
        end else begin
            state_reg <= state_next;
            digit_reg <= digit_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        digit_next = digit_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.digit  = digit_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    digit_next = DIG_SHIFT;
                    state_next = s_first ? ST_SEED : ST_FILL;
                end
            end
            ST_SEED: begin
                if (sts.cnt_zero) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.fib_step = 1'b1;
                end
            end
            ST_FILL: begin
                cmd.fill   = sts.src_zero;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div = 1'b1;
                if (digit_reg == DIG_SHIFT) begin
                    digit_next = DIG_TOGGLE;
                    state_next = ST_FILL;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- hdl/fdbd_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdbd_dp
// fibonacci pair, digit source, divide-by-ten unit and output register
// ----------------------------------------------------------------------------
module fdbd_dp
    import fdbd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [ByteW-1:0] s_data,
    input  logic             s_first,
    input  fdbd_cmd_t        cmd,
    output fdbd_sts_t        sts,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [ByteW-1:0] m_data
);

    logic [FibW-1:0]   fib_now_reg, fib_now_next;
    logic [FibW-1:0]   fib_before_reg, fib_before_next;
    logic [FibW-1:0]   src_reg, src_next;
    logic [ByteW-1:0]  cnt_reg, cnt_next;
    logic [ByteW-1:0]  byte_reg, byte_next;
    logic [QuoW-1:0]   quo_reg, quo_next;
    logic [DigitW-1:0] shift_reg, shift_next;
    logic [DigitW-1:0] toggle_reg, toggle_next;
    logic [ByteW-1:0]  out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic                src_neg;
    logic [FibW-1:0]     src_mag;
    logic [2*FibW-1:0]   product;
    logic [FibW-1:0]     quo_ext;
    logic [FibW-1:0]     quo_x10;
    logic [3:0]          rem;
    logic [DigitW-1:0]   digit;
    logic [ByteW-1:0]    toggled;
    logic [2*ByteW-1:0]  rot_wide;

    // magnitude and reciprocal multiply
    assign src_neg = src_reg[FibW-1];
    assign src_mag = src_neg ? (~src_reg + FibW'(1)) : src_reg;
    assign product = src_mag * RecipTen;

    // remainder from registered quotient
    assign quo_ext = {{(FibW-QuoW){1'b0}}, quo_reg};
    assign quo_x10 = (quo_ext << 3) + (quo_ext << 1);
    assign rem     = src_mag[3:0] - quo_x10[3:0];
    assign digit   = src_neg ? (~rem[DigitW-1:0] + DigitW'(1)) : rem[DigitW-1:0];

    // toggle then rotate left
    assign toggled  = byte_reg ^ toggle_mask(toggle_reg);
    assign rot_wide = {toggled, toggled} << shift_reg;

    assign sts.src_zero = (src_reg == '0);
    assign sts.cnt_zero = (cnt_reg == '0);
    assign sts.out_busy = out_valid_reg && !m_ready;

    always_comb begin
        fib_now_next    = fib_now_reg;
        fib_before_next = fib_before_reg;
        src_next        = src_reg;
        cnt_next        = cnt_reg;
        byte_next       = byte_reg;
        quo_next        = quo_reg;
        shift_next      = shift_reg;
        toggle_next     = toggle_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_ready;

        if (cmd.load) begin
            byte_next = s_data;
            if (s_first) begin
                fib_now_next    = {{(FibW-1){1'b0}}, 1'b1};
                fib_before_next = '0;
                src_next        = '0;
                cnt_next        = s_data;
            end
        end
        if (cmd.fib_step || cmd.fill) begin
            fib_now_next    = fib_now_reg + fib_before_reg;
            fib_before_next = fib_now_reg;
        end
        if (cmd.fib_step) begin
            cnt_next = cnt_reg - ByteW'(1);
        end
        if (cmd.fill) begin
            src_next = fib_now_reg;
        end
        if (cmd.mul) begin
            quo_next = product[RecipShift +: QuoW];
        end
        if (cmd.div) begin
            src_next = src_neg ? (~quo_ext + FibW'(1)) : quo_ext;
            if (cmd.digit == DIG_SHIFT) begin
                shift_next = digit;
            end else begin
                toggle_next = digit;
            end
        end
        if (cmd.out_load) begin
            out_next       = rot_wide[2*ByteW-1 -: ByteW];
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fib_now_reg    <= {{(FibW-1){1'b0}}, 1'b1};
            fib_before_reg <= '0;
            src_reg        <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            fib_now_reg    <= fib_now_next;
            fib_before_reg <= fib_before_next;
            src_reg        <= src_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        quo_reg    <= quo_next;
        shift_reg  <= shift_next;
        toggle_reg <= toggle_next;
        out_reg    <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ----- test/tb_fibonacci_digit_byte_descrambler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fibonacci_digit_byte_descrambler
// self-checking stream test: a directed table of seed and data words, then
// random seeded streams with random idling on both sides and one long result
// back-pressure; each word is matched against a typed byte or the local descrambler model
// ----------------------------------------------------------------------------
module tb_fibonacci_digit_byte_descrambler;
    import fdbd_pkg::*;

    localparam int unsigned TotalWords = 450;
    localparam int unsigned QuietFrom  = 390;     // no idling past this word count
    localparam int unsigned HoldAt     = 150;     // long sink hold-off starts here
    localparam int unsigned HoldCycles = 400;
    localparam int unsigned DrainWait  = 300;     // longest seed word plus latency
    localparam int unsigned CycleLimit = 500000;

    // xor masks picked by the toggle digit
    localparam logic [ByteW-1:0] ToggleMask [8] = '{
        8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h80
    };

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             seed;    // word carries a seed
        logic             typed;   // word expects the plain byte below, not the model value
        logic [ByteW-1:0] plain;
    } stim_row_t;

    localparam int unsigned NumDirected = 23;
    localparam stim_row_t Directed [NumDirected] = '{
        // straight out of reset, pair (1,0): digits 1/1 then 2/3
        '{8'h00, 1'b0, 1'b1, 8'h02},
        '{8'hFF, 1'b0, 1'b1, 8'hEF},
        // seed of zero restores the reset sequence
        '{8'h00, 1'b1, 1'b0, 8'h00},
        '{8'h00, 1'b0, 1'b1, 8'h02},
        '{8'hFF, 1'b0, 1'b1, 8'hEF},
        // seed 5 refills with 8, so the shift digit masks to zero
        '{8'h05, 1'b1, 1'b0, 8'h00},
        '{8'h5A, 1'b0, 1'b0, 8'h00},
        '{8'h01, 1'b0, 1'b0, 8'h00},
        '{8'h80, 1'b0, 1'b0, 8'h00},
        // largest seed, wrapped fibonacci values
        '{8'hFF, 1'b1, 1'b0, 8'h00},
        '{8'h00, 1'b0, 1'b0, 8'h00},
        '{8'hFF, 1'b0, 1'b0, 8'h00},
        '{8'hA5, 1'b0, 1'b0, 8'h00},
        '{8'h3C, 1'b0, 1'b0, 8'h00},
        // seed 46 loads a value with the sign bit set: negative digits
        '{8'h2E, 1'b1, 1'b0, 8'h00},
        '{8'h7E, 1'b0, 1'b0, 8'h00},
        '{8'h81, 1'b0, 1'b0, 8'h00},
        '{8'hC3, 1'b0, 1'b0, 8'h00},
        '{8'h01, 1'b1, 1'b0, 8'h00},
        '{8'h55, 1'b0, 1'b0, 8'h00},
        '{8'hAA, 1'b0, 1'b0, 8'h00},
        '{8'h80, 1'b1, 1'b0, 8'h00},
        '{8'hC3, 1'b0, 1'b0, 8'h00}
    };

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [ByteW-1:0] s_tdata;    // [7:0] data_byte
    logic             s_tuser;    // [0] first_byte
    logic             m_tvalid;
    logic             m_tready;
    logic [ByteW-1:0] m_tdata;    // [7:0] plain_byte

    // model state, mirrors the block's pair and digit source
    logic [FibW-1:0]  fib_cur;
    logic [FibW-1:0]  fib_prev;
    logic [FibW-1:0]  digit_pool;

    logic [ByteW-1:0] plain_expected [$];
    int unsigned      words_sent;
    int unsigned      mismatches;
    int unsigned      cycle_count;
    logic             quiet;

    fibonacci_digit_byte_descrambler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // descrambler model
    // ------------------------------------------------------------------------

    // yields the current value, then moves the pair one step (wraps at 2^32)
    function automatic logic [FibW-1:0] fib_next();
        logic [FibW-1:0] cur;
        cur      = fib_cur;
        fib_cur  = fib_cur + fib_prev;
        fib_prev = cur;
        return cur;
    endfunction

    // signed remainder and quotient by ten, both truncating toward zero
    function automatic logic [DigitW-1:0] pull_digit();
        logic signed [FibW-1:0] src;
        if (digit_pool == '0) begin
            digit_pool = fib_next();
        end
        src        = digit_pool;
        digit_pool = src / 32'sd10;
        return DigitW'(src % 32'sd10);
    endfunction

    function automatic void restart_stream(input logic [ByteW-1:0] seed);
        fib_cur    = 32'd1;
        fib_prev   = 32'd0;
        for (int i = 0; i < seed; i++) begin
            void'(fib_next());
        end
        digit_pool = '0;
    endfunction

    function automatic logic [ByteW-1:0] descramble_byte(input logic [ByteW-1:0] enc);
        logic [DigitW-1:0]  rot;
        logic [DigitW-1:0]  tog;
        logic [ByteW-1:0]   flipped;
        logic [2*ByteW-1:0] twice;
        rot     = pull_digit();
        tog     = pull_digit();
        flipped = enc ^ ToggleMask[tog];
        // rotate left: top byte of the doubled word shifted up
        twice   = {flipped, flipped} << rot;
        return twice[2*ByteW-1:ByteW];
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // offer one word and hold it until taken; typed rows bypass the model value
    task automatic put_word(input logic [ByteW-1:0] data, input logic seed,
                            input logic typed, input logic [ByteW-1:0] plain);
        logic [ByteW-1:0] modeled;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= seed;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        words_sent++;
        if (words_sent >= QuietFrom) begin
            quiet = 1'b1;
        end
        if (seed) begin
            restart_stream(data);
        end else begin
            modeled = descramble_byte(data);
            plain_expected = {plain_expected, (typed ? plain : modeled)};
        end
    endtask

    // random idle burst between words with valid low, never once quiet is set
    task automatic maybe_idle();
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    task automatic put_random_byte();
        put_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, 8'h00);
        maybe_idle();
    endtask

    initial begin : source
        int unsigned run_len;
        logic [ByteW-1:0] seed;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        quiet      = 1'b0;
        words_sent = 0;
        fib_cur    = 32'd1;
        fib_prev   = 32'd0;
        digit_pool = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (Directed[i]) begin
            put_word(Directed[i].data, Directed[i].seed, Directed[i].typed,
                     Directed[i].plain);
            maybe_idle();
        end

        // seeded streams of random length; seeds mostly short so the pair
        // step loop stays cheap, now and then a large one
        while (words_sent < TotalWords) begin
            // a few streams simply continue the previous one without a seed
            if ($urandom_range(0, 9) != 0) begin
                seed = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 60));
                put_word(seed, 1'b1, 1'b0, 8'h00);
                maybe_idle();
            end
            // mostly short runs, sometimes long ones that drain many digits
            run_len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
            repeat (run_len) put_random_byte();
        end
        s_tvalid <= 1'b0;

        while (plain_expected.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DrainWait) @(posedge aclk);
        if (mismatches == 0) begin
            $display("fibonacci_digit_byte_descrambler regression: pass");
        end else begin
            $display("fibonacci_digit_byte_descrambler regression: fail");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    // ready toggles in random bursts; one long hold-off lets the block back up
    initial begin : sink
        logic held;
        held     = 1'b0;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!held && words_sent >= HoldAt) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    // compare each result word with the oldest pending plain byte
    initial mismatches = 0;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (plain_expected.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result word, expected none actual %02h",
                         $time, m_tdata);
            end else if (m_tdata !== plain_expected[0]) begin
                mismatches++;
                $display("%0t: plain_byte mismatch, expected %02h actual %02h",
                         $time, plain_expected[0], m_tdata);
                void'(plain_expected.pop_front());
            end else begin
                void'(plain_expected.pop_front());
            end
        end
    end

    // watchdog
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("fibonacci_digit_byte_descrambler regression: fail");
            $finish;
        end
    end

endmodule
